// ===== hw/rtl/scpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_pkg - shared types and constants of the packet framer
// Word formats of both channels, the command format of the internal queue
// and the fixed header bytes.
// ----------------------------------------------------------------------------
package scpf_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] ID_BYTE_A = 8'h04;
  localparam logic [7:0] ID_BYTE_B = 8'h69;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Byte positions within the header sequence
  localparam logic [2:0] HDR_SYNC_A = 3'd0;
  localparam logic [2:0] HDR_SYNC_B = 3'd1;
  localparam logic [2:0] HDR_ID_A   = 3'd2;
  localparam logic [2:0] HDR_ID_B   = 3'd3;
  localparam logic [2:0] HDR_LEN_HI = 3'd4;
  localparam logic [2:0] HDR_LEN_LO = 3'd5;
  localparam logic [2:0] HDR_SUM    = 3'd6;

  typedef struct packed {
    logic        kind;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       unexpected_byte;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_DATA,
    CMD_DROP
  } cmd_op_t;

  // One classified word: value holds the length for a header, the payload
  // byte in its low half for a data word; sum is the checksum to send on close.
  typedef struct packed {
    cmd_op_t     op;
    logic        close;
    logic [15:0] value;
    logic [7:0]  sum;
  } cmd_t;

endpackage

// ===== hw/rtl/sum_checked_packet_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_checked_packet_framer - framer with additive checksum
// Wraps a length-prefixed payload into a serial frame: sync bytes, id
// bytes, length, payload and an 8-bit wrapping checksum.
// ----------------------------------------------------------------------------
//
// Channel | Handshake                   | Word
// --------+-----------------------------+---------------------------------
// item    | item_valid in, item_stall out | kind, frame_length, payload_byte
// tx      | tx_valid out, tx_stall in   | tx_byte, frame_end, unexpected_byte
//
// Flow: the classifier takes one word per cycle while the command queue
// has room. The byte sequencer sends one byte per cycle while tx_stall is
// low or the output register is empty; a start word yields six bytes (seven
// for a zero length), a payload word one (two when it closes the frame) and a stray payload word one.
// Reset: synchronous on rst; clears the frame state, the queue and the
// output register's valid flag.
// Stalls: tx_stall holds the output register; the queue absorbs up to
// QUEUE_DEPTH classified words before item_stall rises.
// ----------------------------------------------------------------------------
module sum_checked_packet_framer import scpf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_word_t  item,
  output logic      tx_valid,
  input  logic      tx_stall,
  output out_word_t tx
);

  logic push;
  logic pop;
  logic empty;
  logic full;
  cmd_t push_cmd;
  cmd_t head;

  // Hold the input whenever the queue has no free slot
  assign item_stall = full;

  // Classify the word and advance the frame state
  scpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .queue_full (full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Decouple classification from byte output
  scpf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Expand each command into its bytes; drop the command once its last
  // byte is loaded into the output register
  scpf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx       (tx)
  );

endmodule

// ===== hw/rtl/scpf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_front - word classifier
// Accepts input words, tracks the open frame and its running checksum, and
// issues one command per word to the queue.
// ----------------------------------------------------------------------------
module scpf_front import scpf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  in_word_t item,
  input  logic     queue_full,
  output logic     push,
  output cmd_t     push_cmd
);

  logic        frame_open, frame_open_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  running_sum, running_sum_next;

  logic [7:0]  hdr_sum;
  logic [7:0]  data_sum;
  logic [15:0] left_dec;

  assign push     = item_valid && !queue_full;
  assign hdr_sum  = ID_BYTE_A + ID_BYTE_B + item.frame_length[15:8] + item.frame_length[7:0];
  assign data_sum = running_sum + item.payload_byte;
  assign left_dec = bytes_left - 16'd1;

  always_comb begin
    push_cmd         = '0;
    frame_open_next  = frame_open;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    priority if (item.kind == KIND_START) begin
      push_cmd.op    = CMD_HEADER;
      push_cmd.value = item.frame_length;
      push_cmd.sum   = hdr_sum;
      push_cmd.close = (item.frame_length == 16'd0);
      if (push_cmd.close) begin
        frame_open_next  = 1'b0;
        bytes_left_next  = '0;
        running_sum_next = '0;
      end else begin
        frame_open_next  = 1'b1;
        bytes_left_next  = item.frame_length;
        running_sum_next = hdr_sum;
      end
    end else if (!frame_open) begin
      push_cmd.op = CMD_DROP;
    end else begin
      push_cmd.op     = CMD_DATA;
      push_cmd.value  = {8'd0, item.payload_byte};
      push_cmd.sum    = data_sum;
      push_cmd.close  = (left_dec == 16'd0);
      bytes_left_next = left_dec;
      if (push_cmd.close) begin
        frame_open_next  = 1'b0;
        running_sum_next = '0;
      end else begin
        running_sum_next = data_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      bytes_left  <= '0;
      running_sum <= '0;
    end else if (push) begin
      frame_open  <= frame_open_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

// ===== hw/rtl/scpf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_queue - command queue
// Short first-in first-out store between classifier and byte sequencer;
// the head entry is read combinationally.
// ----------------------------------------------------------------------------
module scpf_queue import scpf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  cmd_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CntFull);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/scpf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_back - byte sequencer
// Expands the head command into its transmit bytes, one per cycle while the
// output register is empty or tx_stall is low, into the output register.
// ----------------------------------------------------------------------------
module scpf_back import scpf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      head,
  input  logic      empty,
  output logic      pop,
  output logic      tx_valid,
  input  logic      tx_stall,
  output out_word_t tx
);

  logic [2:0] step;
  logic       advance;
  logic       last_step;
  out_word_t  sel;

  assign advance = !empty && (!tx_valid || !tx_stall);
  assign pop     = advance && last_step;

  always_comb begin
    sel       = '0;
    last_step = 1'b1;
    unique case (head.op)
      CMD_HEADER: begin
        last_step = head.close ? (step == HDR_SUM) : (step == HDR_LEN_LO);
        unique case (step)
          HDR_SYNC_A, HDR_SYNC_B: sel.tx_byte = SYNC_BYTE;
          HDR_ID_A:   sel.tx_byte = ID_BYTE_A;
          HDR_ID_B:   sel.tx_byte = ID_BYTE_B;
          HDR_LEN_HI: sel.tx_byte = head.value[15:8];
          HDR_LEN_LO: sel.tx_byte = head.value[7:0];
          default: begin
            sel.tx_byte   = head.sum;
            sel.frame_end = 1'b1;
          end
        endcase
      end
      CMD_DATA: begin
        last_step = head.close ? (step != 3'd0) : 1'b1;
        if (step == 3'd0) begin
          sel.tx_byte = head.value[7:0];
        end else begin
          sel.tx_byte   = head.sum;
          sel.frame_end = 1'b1;
        end
      end
      default: begin
        sel.unexpected_byte = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      tx_valid <= 1'b0;
    end else begin
      if (pop) begin
        step <= '0;
      end else if (advance) begin
        step <= step + 3'd1;
      end
      if (advance) begin
        tx_valid <= 1'b1;
      end else if (!tx_stall) begin
        tx_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx <= sel;
    end
  end

endmodule

// ===== hw/rtl/scpf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_checker - port-level checks of the packet framer
// Watches the output channel for handshake and word-format slips.
// ----------------------------------------------------------------------------
module scpf_checker import scpf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      tx_valid,
  input logic      tx_stall,
  input out_word_t tx
);

  a_tx_hold_valid: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_stall |=> tx_valid)
    else $error("tx word withdrawn while stalled");

  a_tx_hold_word: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_stall |=> $stable(tx))
    else $error("tx word changed while stalled");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    tx_valid |-> !(tx.frame_end && tx.unexpected_byte))
    else $error("checksum byte flagged as unexpected");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx.unexpected_byte |-> tx.tx_byte == 8'd0)
    else $error("dropped word carries a non-zero byte");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !tx_valid)
    else $error("tx valid right after reset");

endmodule

bind sum_checked_packet_framer scpf_checker u_scpf_checker (
  .clk      (clk),
  .rst      (rst),
  .tx_valid (tx_valid),
  .tx_stall (tx_stall),
  .tx       (tx)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the checksummed packet framer
// Drives start and payload words into the framer and predicts every byte of
// each frame: the header, the payload pass-through, the closing checksum and
// the flag for stray payload bytes. Each received word is checked field by
// field against the oldest prediction. The run covers four idling phases:
// none, sender gaps, receiver stalls, and both together.
// ----------------------------------------------------------------------------

// Frame predictor and store of the transmit words still to arrive.
class frame_checker;
  scpf_pkg::out_word_t pending_tx[$];

  // Predicted frame state
  bit          open_q;
  bit [15:0]   left_q;
  bit [7:0]    sum_q;

  int unsigned mismatches;
  int unsigned stray_results;
  int unsigned shown;
  int unsigned checked;
  int unsigned frames_closed;
  int unsigned bytes_flagged;

  function new();
    open_q        = 1'b0;
    left_q        = '0;
    sum_q         = '0;
    mismatches    = 0;
    stray_results = 0;
    shown         = 0;
    checked       = 0;
    frames_closed = 0;
    bytes_flagged = 0;
  endfunction

  function void add_byte(logic [7:0] b, logic last, logic bad);
    scpf_pkg::out_word_t o;
    o.tx_byte         = b;
    o.frame_end       = last;
    o.unexpected_byte = bad;
    pending_tx.push_back(o);
  endfunction

  // Work out the transmit words that one accepted input word causes.
  function void note_word(scpf_pkg::in_word_t w);
    logic [7:0] hdr_sum;
    if (w.kind == scpf_pkg::KIND_START) begin
      // A start always abandons whatever frame was open
      hdr_sum = scpf_pkg::ID_BYTE_A + scpf_pkg::ID_BYTE_B
              + w.frame_length[15:8] + w.frame_length[7:0];
      add_byte(scpf_pkg::SYNC_BYTE, 1'b0, 1'b0);
      add_byte(scpf_pkg::SYNC_BYTE, 1'b0, 1'b0);
      add_byte(scpf_pkg::ID_BYTE_A, 1'b0, 1'b0);
      add_byte(scpf_pkg::ID_BYTE_B, 1'b0, 1'b0);
      add_byte(w.frame_length[15:8], 1'b0, 1'b0);
      add_byte(w.frame_length[7:0], 1'b0, 1'b0);
      if (w.frame_length == 16'd0) begin
        add_byte(hdr_sum, 1'b1, 1'b0);
        open_q = 1'b0;
        left_q = '0;
        sum_q  = '0;
        frames_closed++;
      end else begin
        open_q = 1'b1;
        left_q = w.frame_length;
        sum_q  = hdr_sum;
      end
    end else if (!open_q) begin
      add_byte(8'h00, 1'b0, 1'b1);
      bytes_flagged++;
    end else begin
      add_byte(w.payload_byte, 1'b0, 1'b0);
      sum_q  = sum_q + w.payload_byte;
      left_q = left_q - 16'd1;
      if (left_q == 16'd0) begin
        add_byte(sum_q, 1'b1, 1'b0);
        open_q = 1'b0;
        sum_q  = '0;
        frames_closed++;
      end
    end
  endfunction

  // Compare one received transmit word with the oldest prediction.
  function void check_tx(scpf_pkg::out_word_t got);
    scpf_pkg::out_word_t exp_w;
    if (pending_tx.size() == 0) begin
      stray_results++;
      if (shown < 10) begin
        shown++;
        $display("tx word with nothing pending: tx_byte=%02h frame_end=%0b unexpected_byte=%0b",
                 got.tx_byte, got.frame_end, got.unexpected_byte);
      end
      return;
    end
    exp_w = pending_tx.pop_front();
    checked++;
    if (got.tx_byte !== exp_w.tx_byte || got.frame_end !== exp_w.frame_end ||
        got.unexpected_byte !== exp_w.unexpected_byte) begin
      mismatches++;
      if (shown < 10) begin
        shown++;
        $display("tx mismatch at word %0d: tx_byte exp %02h got %02h, frame_end exp %0b got %0b, unexpected_byte exp %0b got %0b",
                 checked, exp_w.tx_byte, got.tx_byte, exp_w.frame_end, got.frame_end,
                 exp_w.unexpected_byte, got.unexpected_byte);
      end
    end
  endfunction
endclass

module tb;
  import scpf_pkg::*;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  in_word_t  item;
  logic      tx_valid;
  logic      tx_stall = 1'b0;
  out_word_t tx;

  // Idling odds in percent per cycle; the phase sequence sets them
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned words_sent    = 0;

  frame_checker chk = new();

  sum_checked_packet_framer u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .tx_valid   (tx_valid),
    .tx_stall   (tx_stall),
    .tx         (tx)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run well beyond the slowest legal drain.
  initial begin
    #5_000_000;
    $display("[sum_checked_packet_framer] ERROR");
    $finish;
  end

  // Receiver: check each accepted word, then pick the stall for the next
  // cycle. Sampling just after the edge sees the values from before it.
  always @(posedge clk) begin
    if (!rst && tx_valid === 1'b1 && !tx_stall) begin
      chk.check_tx(tx);
    end
    tx_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Offer one input word, with random idle cycles ahead of it, and hold it
  // until accepted. Valid stays high straight into the next word when no
  // idle cycle is drawn.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (item_stall !== 1'b0);
    chk.note_word(w);
    words_sent++;
  endtask

  // Start word; the unused payload field gets random content.
  task automatic send_start(input logic [15:0] len);
    in_word_t w;
    w.kind         = KIND_START;
    w.frame_length = len;
    w.payload_byte = 8'($urandom);
    send_word(w);
  endtask

  // Payload word; the unused length field gets random content.
  task automatic send_data(input logic [7:0] b);
    in_word_t w;
    w.kind         = KIND_PAYLOAD;
    w.frame_length = 16'($urandom);
    w.payload_byte = b;
    send_word(w);
  endtask

  // One random stretch of traffic: mostly complete short frames, with stray
  // bytes, abandoned frames of any length and raw noise mixed in.
  task automatic random_burst();
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    in_word_t    w;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      send_start(16'(len));
      repeat (len) send_data(8'($urandom));
    end else if (pick < 84) begin
      // Stray when the last frame closed; otherwise more payload for it
      repeat ($urandom_range(1, 3)) send_data(8'($urandom));
    end else if (pick < 94) begin
      // Open a frame that the next start will abandon
      len = $urandom_range(1, 65535);
      n   = $urandom_range(0, 4);
      if (n >= len) n = len - 1;
      send_start(16'(len));
      repeat (n) send_data(8'($urandom));
    end else begin
      w.kind         = 1'($urandom);
      w.frame_length = 16'($urandom);
      w.payload_byte = 8'($urandom);
      send_word(w);
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned leftover;
    int unsigned failures;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words, no idling.
    send_data(8'hA5);                 // stray byte straight after reset
    send_start(16'h0000);             // empty frame: header then checksum
    send_start(16'h0001);
    send_data(8'h00);
    send_start(16'h0002);             // checksum wraps past 8 bits
    send_data(8'hFF);
    send_data(8'hFF);
    send_start(16'hFFFF);             // largest length, abandoned below
    send_data(8'h12);
    send_data(8'h34);
    send_start(16'h8000);             // abandons the open frame
    send_start(16'h0003);
    send_data(8'hFF);
    send_data(8'h80);
    send_data(8'h7F);
    send_data(8'hFF);                 // stray byte after a closed frame
    send_data(8'h00);
    send_start(16'hFF00);
    send_start(16'h0000);             // empty frame abandoning an open one

    // Random traffic across the idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 78; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 78; end
        default: begin src_idle_pct = 34; sink_stall_pct = 34; end
      endcase
      target = words_sent + 98;
      while (words_sent < target) random_burst();
    end

    // Drop valid and drain everything still predicted.
    item_valid     <= 1'b0;
    sink_stall_pct = 0;
    while (chk.pending_tx.size() != 0) @(posedge clk);
    // Hold a little longer to catch any word the framer should not send.
    repeat (20) @(posedge clk);

    leftover = chk.pending_tx.size();
    failures = chk.mismatches + chk.stray_results + leftover;
    $display("Run covered %0d input words: %0d frames closed, %0d stray bytes flagged.",
             words_sent, chk.frames_closed, chk.bytes_flagged);
    $display("Checked %0d tx words; %0d mismatched, %0d unexpected, %0d missing.",
             chk.checked, chk.mismatches, chk.stray_results, leftover);
    if (failures == 0) begin
      $display("[sum_checked_packet_framer] OK");
    end else begin
      $display("[sum_checked_packet_framer] ERROR");
    end
    $finish;
  end

endmodule

// ===== sum_checked_packet_framer.f =====
hw/rtl/scpf_pkg.sv
hw/rtl/scpf_front.sv
hw/rtl/scpf_queue.sv
hw/rtl/scpf_back.sv
hw/rtl/sum_checked_packet_framer.sv
hw/rtl/scpf_checker.sv
tb/sv/tb.sv
